@@ rtl/core/mle_pkg.sv @@
package mle_pkg;

    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    typedef enum logic [2:0] {
        FN_APPEND  = 3'd0,
        FN_UNLINK  = 3'd1,
        FN_ENABLE  = 3'd2,
        FN_DISABLE = 3'd3,
        FN_PUT     = 3'd4,
        FN_GET     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MATCHED  = 3'd1,
        ST_NO_MATCH = 3'd2,
        ST_DISABLED = 3'd3,
        ST_BUSY     = 3'd4,
        ST_FULL     = 3'd5,
        ST_UNUSED   = 3'd6
    } status_t;

    localparam int OPT_NO_TRUNC = 0;
    localparam int OPT_MANAGE   = 1;
    localparam int OPT_ONCE     = 2;
    localparam int OPT_NID_ANY  = 3;
    localparam int OPT_PID_ANY  = 4;

    typedef struct packed {
        logic [63:0] mbits;
        logic [63:0] ibits;
        logic [15:0] nid;
        logic [15:0] pid;
        logic [31:0] length;
        logic [31:0] mfree;
        logic [4:0]  flags;
        logic [31:0] loff;
    } entry_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_UL_HOME,
        SQ_UL_RD,
        SQ_UL_CMP,
        SQ_H_NEXT,
        SQ_H_ENT,
        SQ_H_CHK,
        SQ_H_UPD1,
        SQ_H_UPD2,
        SQ_SH_RD,
        SQ_SH_WR,
        SQ_DONE
    } seq_t;

endpackage

@@ rtl/core/mle_ram.sv @@
module mle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/match_list_engine.sv @@
// Match engine for a portal table. One command or header is handled at a time.
// Append, enable and disable act in the decode state, then the result is output.
// Unlink reads the entry's home list one slot at a time to find the handle, then
// closes the gap by moving each following slot down by one. A header scans each
// candidate entry (slot memory read, entry memory read, compare), over the priority
// list then the overflow list, then runs the update states and, on auto-unlink,
// the same slot list compaction. The slot and entry memories each have one read
// port. No clearing pass follows reset.
module match_list_engine #(
    parameter int ENTRY_COUNT  = 64,
    parameter int PORTAL_COUNT = 16,
    parameter int LIST_DEPTH   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_handle, portal_index, match mask, ignore mask, peer_nid, peer_pid,
    // length, offset, options, minimum free, zero pad
    input  logic [mle_pkg::IN_DATA_W-1:0]    s_tdata,
    // func, list_select
    input  logic [mle_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // matched_handle, matched_list, data_offset, match_length, unlinked
    output logic [mle_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status
    output logic [mle_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam int EW    = $clog2(ENTRY_COUNT);
    localparam int PW    = (PORTAL_COUNT > 1) ? $clog2(PORTAL_COUNT) : 1;
    localparam int HMW   = PW + 1;
    localparam int HOMES = 2 * PORTAL_COUNT;
    localparam int LW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int FW    = $clog2(LIST_DEPTH + 1);
    localparam int SAW   = HMW + LW;
    localparam int EWORD = $bits(mle_pkg::entry_t) + HMW;

    mle_pkg::seq_t state_reg, state_next;

    logic [2:0]  func_reg;
    logic [5:0]  h_reg;
    logic [3:0]  pt_reg;
    logic        ls_reg;
    logic [63:0] mb_reg, ib_reg;
    logic [15:0] nid_reg, pid_reg;
    logic [31:0] len_reg, off_reg, mf_reg;
    logic [4:0]  opt_reg;

    logic [ENTRY_COUNT-1:0]  in_use_reg;
    logic [PORTAL_COUNT-1:0] en_reg;
    logic [FW-1:0]           fill_reg [HOMES];

    logic                lst_reg;
    logic [FW-1:0]       idx_reg;
    logic [HMW-1:0]      home_reg;
    logic [EW-1:0]       cand_reg;
    mle_pkg::entry_t     ent_reg;
    logic [31:0]         offe_reg, lo_new_reg, room_reg;

    logic [2:0]  rs_status_reg;
    logic [5:0]  rs_handle_reg;
    logic        rs_list_reg, rs_unl_reg;
    logic [31:0] rs_off_reg, rs_len_reg;

    logic                          out_valid_reg;
    logic [mle_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [mle_pkg::OUT_USER_W-1:0] out_user_reg;

    // memories
    logic            e_wr_en, e_rd_en;
    logic [EW-1:0]   e_wr_addr, e_rd_addr;
    logic [EWORD-1:0] e_wr_data, e_rd_data;
    logic            s_wr_en, s_rd_en;
    logic [SAW-1:0]  s_wr_addr, s_rd_addr;
    logic [EW-1:0]   s_wr_data, s_rd_data;

    mle_ram #(.WIDTH(EWORD), .DEPTH(ENTRY_COUNT)) u_entry_ram (
        .clk     (clk),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_en   (e_rd_en),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    mle_ram #(.WIDTH(EW), .DEPTH(2 ** SAW)) u_slot_ram (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

    // decode helpers
    logic [31:0]     h_ext, pt_ext;
    logic [EW-1:0]   h_idx;
    logic [PW-1:0]   pt_idx;
    logic            h_ok, pt_ok;
    logic [HMW-1:0]  app_home, hdr_home;
    logic [FW-1:0]   app_fill, hdr_fill, home_fill, idx_p1;
    logic            is_put;

    assign h_ext    = {26'd0, h_reg};
    assign pt_ext   = {28'd0, pt_reg};
    assign h_idx    = h_ext[EW-1:0];
    assign pt_idx   = pt_ext[PW-1:0];
    assign h_ok     = h_ext < ENTRY_COUNT;
    assign pt_ok    = pt_ext < PORTAL_COUNT;
    assign app_home = {pt_idx, ls_reg};
    assign hdr_home = {pt_idx, lst_reg};
    assign app_fill = fill_reg[app_home];
    assign hdr_fill = fill_reg[hdr_home];
    assign home_fill = fill_reg[home_reg];
    assign idx_p1   = idx_reg + FW'(1);
    assign is_put   = func_reg == mle_pkg::FN_PUT;

    // entry word fields on read
    mle_pkg::entry_t e_rd;
    logic [HMW-1:0]  e_rd_home;
    assign e_rd      = e_rd_data[$bits(mle_pkg::entry_t)-1:0];
    assign e_rd_home = e_rd_data[EWORD-1:$bits(mle_pkg::entry_t)];

    // candidate check
    logic        c_match, c_trunc_fail, c_nid_ok, c_pid_ok, c_hit;
    logic [31:0] c_off;
    logic [32:0] c_sum;
    always_comb
    begin
        c_match = ((mb_reg ^ e_rd.mbits) & ~e_rd.ibits) == 64'd0;
        c_off = (is_put && e_rd.flags[mle_pkg::OPT_MANAGE]) ? e_rd.loff : off_reg;
        c_sum = {1'b0, c_off} + {1'b0, len_reg};
        c_trunc_fail = e_rd.flags[mle_pkg::OPT_NO_TRUNC] && (c_sum > {1'b0, e_rd.length});
        c_nid_ok = e_rd.flags[mle_pkg::OPT_NID_ANY] || (e_rd.nid == nid_reg);
        c_pid_ok = e_rd.flags[mle_pkg::OPT_PID_ANY] || (e_rd.pid == pid_reg);
        c_hit = c_match && !c_trunc_fail && c_nid_ok && c_pid_ok;
    end

    // update arithmetic
    logic        u_manage;
    logic [31:0] u_off, u_lo;
    logic [32:0] u_sum;
    logic [31:0] u_len, u_rest;
    logic        u_unl;
    always_comb
    begin
        u_manage = is_put && ent_reg.flags[mle_pkg::OPT_MANAGE];
        u_off = u_manage ? ent_reg.loff : off_reg;
        u_sum = {1'b0, ent_reg.loff} + {1'b0, len_reg};
        u_lo = ent_reg.loff;
        if (u_manage)
        begin
            u_lo = u_sum[32] ? 32'hFFFF_FFFF : u_sum[31:0];
        end
        u_len = len_reg;
        if (is_put && !ent_reg.flags[mle_pkg::OPT_NO_TRUNC] && (len_reg > room_reg))
        begin
            u_len = room_reg;
        end
        u_rest = (ent_reg.length > lo_new_reg) ? ent_reg.length - lo_new_reg : 32'd0;
        u_unl = is_put && (ent_reg.flags[mle_pkg::OPT_ONCE] || (u_rest < ent_reg.mfree));
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mle_pkg::SQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mle_pkg::SQ_DECODE;
                end
            end
            mle_pkg::SQ_DECODE:
            begin
                state_next = mle_pkg::SQ_DONE;
                case (func_reg)
                    mle_pkg::FN_UNLINK:
                    begin
                        if (h_ok && in_use_reg[h_idx])
                        begin
                            state_next = mle_pkg::SQ_UL_HOME;
                        end
                    end
                    mle_pkg::FN_PUT, mle_pkg::FN_GET:
                    begin
                        if (pt_ok && en_reg[pt_idx])
                        begin
                            state_next = mle_pkg::SQ_H_NEXT;
                        end
                    end
                    default: state_next = mle_pkg::SQ_DONE;
                endcase
            end
            mle_pkg::SQ_UL_HOME: state_next = mle_pkg::SQ_UL_RD;
            mle_pkg::SQ_UL_RD:
            begin
                state_next = (idx_reg < home_fill) ? mle_pkg::SQ_UL_CMP : mle_pkg::SQ_DONE;
            end
            mle_pkg::SQ_UL_CMP:
            begin
                state_next = (s_rd_data == h_idx) ? mle_pkg::SQ_SH_RD : mle_pkg::SQ_UL_RD;
            end
            mle_pkg::SQ_H_NEXT:
            begin
                if (idx_reg < hdr_fill)
                begin
                    state_next = mle_pkg::SQ_H_ENT;
                end
                else if (lst_reg)
                begin
                    state_next = mle_pkg::SQ_DONE;
                end
            end
            mle_pkg::SQ_H_ENT:
            begin
                state_next = in_use_reg[s_rd_data] ? mle_pkg::SQ_H_CHK : mle_pkg::SQ_H_NEXT;
            end
            mle_pkg::SQ_H_CHK:
            begin
                state_next = c_hit ? mle_pkg::SQ_H_UPD1 : mle_pkg::SQ_H_NEXT;
            end
            mle_pkg::SQ_H_UPD1: state_next = mle_pkg::SQ_H_UPD2;
            mle_pkg::SQ_H_UPD2:
            begin
                state_next = u_unl ? mle_pkg::SQ_SH_RD : mle_pkg::SQ_DONE;
            end
            mle_pkg::SQ_SH_RD:
            begin
                state_next = (idx_p1 < home_fill) ? mle_pkg::SQ_SH_WR : mle_pkg::SQ_DONE;
            end
            mle_pkg::SQ_SH_WR: state_next = mle_pkg::SQ_SH_RD;
            mle_pkg::SQ_DONE:
            begin
                if (out_free)
                begin
                    state_next = mle_pkg::SQ_IDLE;
                end
            end
            default: state_next = mle_pkg::SQ_IDLE;
        endcase
    end

    logic app_ok;
    assign app_ok = h_ok && pt_ok && !in_use_reg[h_idx] && (app_fill < FW'(LIST_DEPTH));

    // memory controls
    always_comb
    begin
        e_wr_en   = 1'b0;
        e_wr_addr = h_idx;
        e_wr_data = {app_home, mb_reg, ib_reg, nid_reg, pid_reg, len_reg, mf_reg,
                     opt_reg, 32'd0};
        e_rd_en   = 1'b0;
        e_rd_addr = h_idx;
        s_wr_en   = 1'b0;
        s_wr_addr = {app_home, app_fill[LW-1:0]};
        s_wr_data = h_idx;
        s_rd_en   = 1'b0;
        s_rd_addr = {home_reg, idx_reg[LW-1:0]};
        case (state_reg)
            mle_pkg::SQ_DECODE:
            begin
                if (func_reg == mle_pkg::FN_APPEND && app_ok)
                begin
                    e_wr_en = 1'b1;
                    s_wr_en = 1'b1;
                end
                e_rd_en = func_reg == mle_pkg::FN_UNLINK;
            end
            mle_pkg::SQ_UL_RD:
            begin
                s_rd_en = 1'b1;
            end
            mle_pkg::SQ_H_NEXT:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = {hdr_home, idx_reg[LW-1:0]};
            end
            mle_pkg::SQ_H_ENT:
            begin
                e_rd_en   = 1'b1;
                e_rd_addr = s_rd_data;
            end
            mle_pkg::SQ_H_UPD2:
            begin
                e_wr_en   = u_manage;
                e_wr_addr = cand_reg;
                e_wr_data = {home_reg, ent_reg.mbits, ent_reg.ibits, ent_reg.nid,
                             ent_reg.pid, ent_reg.length, ent_reg.mfree, ent_reg.flags,
                             lo_new_reg};
            end
            mle_pkg::SQ_SH_RD:
            begin
                s_rd_en   = 1'b1;
                s_rd_addr = {home_reg, idx_p1[LW-1:0]};
            end
            mle_pkg::SQ_SH_WR:
            begin
                s_wr_en   = 1'b1;
                s_wr_addr = {home_reg, idx_reg[LW-1:0]};
                s_wr_data = s_rd_data;
            end
            default: ;
        endcase
    end

    assign s_tready = state_reg == mle_pkg::SQ_IDLE;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mle_pkg::SQ_IDLE;
            in_use_reg    <= '0;
            en_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HOMES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mle_pkg::SQ_DECODE:
                begin
                    if (func_reg == mle_pkg::FN_APPEND && app_ok)
                    begin
                        in_use_reg[h_idx]  <= 1'b1;
                        fill_reg[app_home] <= app_fill + FW'(1);
                    end
                    if ((func_reg == mle_pkg::FN_ENABLE || func_reg == mle_pkg::FN_DISABLE)
                        && pt_ok)
                    begin
                        en_reg[pt_idx] <= func_reg == mle_pkg::FN_ENABLE;
                    end
                end
                mle_pkg::SQ_UL_RD:
                begin
                    // handle missing from its list: just free it
                    if (!(idx_reg < home_fill))
                    begin
                        in_use_reg[h_idx] <= 1'b0;
                    end
                end
                mle_pkg::SQ_SH_RD:
                begin
                    if (!(idx_p1 < home_fill))
                    begin
                        fill_reg[home_reg]   <= home_fill - FW'(1);
                        in_use_reg[cand_reg] <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (state_reg == mle_pkg::SQ_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mle_pkg::SQ_IDLE:
            begin
                func_reg <= s_tuser[2:0];
                ls_reg   <= s_tuser[3];
                h_reg    <= s_tdata[5:0];
                pt_reg   <= s_tdata[9:6];
                mb_reg   <= s_tdata[73:10];
                ib_reg   <= s_tdata[137:74];
                nid_reg  <= s_tdata[153:138];
                pid_reg  <= s_tdata[169:154];
                len_reg  <= s_tdata[201:170];
                off_reg  <= s_tdata[233:202];
                opt_reg  <= s_tdata[238:234];
                mf_reg   <= s_tdata[270:239];
            end
            mle_pkg::SQ_DECODE:
            begin
                rs_status_reg <= mle_pkg::ST_OK;
                rs_handle_reg <= '0;
                rs_list_reg   <= 1'b0;
                rs_off_reg    <= '0;
                rs_len_reg    <= '0;
                rs_unl_reg    <= 1'b0;
                lst_reg       <= 1'b0;
                idx_reg       <= '0;
                case (func_reg)
                    mle_pkg::FN_APPEND:
                    begin
                        if (!h_ok)
                            rs_status_reg <= mle_pkg::ST_UNUSED;
                        else if (!pt_ok)
                            rs_status_reg <= mle_pkg::ST_DISABLED;
                        else if (in_use_reg[h_idx])
                            rs_status_reg <= mle_pkg::ST_BUSY;
                        else if (!(app_fill < FW'(LIST_DEPTH)))
                            rs_status_reg <= mle_pkg::ST_FULL;
                    end
                    mle_pkg::FN_UNLINK:
                    begin
                        if (!(h_ok && in_use_reg[h_idx]))
                            rs_status_reg <= mle_pkg::ST_UNUSED;
                    end
                    mle_pkg::FN_PUT, mle_pkg::FN_GET:
                    begin
                        if (!(pt_ok && en_reg[pt_idx]))
                            rs_status_reg <= mle_pkg::ST_DISABLED;
                    end
                    default: ;
                endcase
            end
            mle_pkg::SQ_UL_HOME:
            begin
                home_reg <= e_rd_home;
            end
            mle_pkg::SQ_UL_CMP:
            begin
                cand_reg <= h_idx;
                if (s_rd_data != h_idx)
                begin
                    idx_reg <= idx_p1;
                end
            end
            mle_pkg::SQ_H_NEXT:
            begin
                if (!(idx_reg < hdr_fill))
                begin
                    if (lst_reg)
                    begin
                        rs_status_reg <= mle_pkg::ST_NO_MATCH;
                    end
                    lst_reg <= 1'b1;
                    idx_reg <= '0;
                end
            end
            mle_pkg::SQ_H_ENT:
            begin
                cand_reg <= s_rd_data;
                if (!in_use_reg[s_rd_data])
                begin
                    idx_reg <= idx_p1;
                end
            end
            mle_pkg::SQ_H_CHK:
            begin
                ent_reg  <= e_rd;
                home_reg <= hdr_home;
                if (!c_hit)
                begin
                    idx_reg <= idx_p1;
                end
            end
            mle_pkg::SQ_H_UPD1:
            begin
                offe_reg   <= u_off;
                lo_new_reg <= u_lo;
                room_reg   <= (ent_reg.length > u_off) ? ent_reg.length - u_off : 32'd0;
            end
            mle_pkg::SQ_H_UPD2:
            begin
                rs_status_reg <= mle_pkg::ST_MATCHED;
                rs_handle_reg <= 6'({{(32 - EW){1'b0}}, cand_reg});
                rs_list_reg   <= home_reg[0];
                rs_off_reg    <= offe_reg;
                rs_len_reg    <= u_len;
                rs_unl_reg    <= u_unl;
            end
            mle_pkg::SQ_SH_WR:
            begin
                idx_reg <= idx_p1;
            end
            mle_pkg::SQ_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= {rs_unl_reg, rs_len_reg, rs_off_reg, rs_list_reg,
                                     rs_handle_reg};
                    out_user_reg <= rs_status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
